// ----- rtl/sgpu_pkg.sv -----
// Shared constants, codes, saturation helpers and the sigmoid table for the skip-gram update engine.
package sgpu_pkg;

  localparam int VOCAB_WORDS = 4096;
  localparam int ROW_W       = 12;
  localparam int DIM_MAX     = 128;
  localparam int COL_W       = 7;
  localparam int DIM_W       = 8;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int W_W         = 16;
  localparam int H_W         = 24;
  localparam int DOT_W       = 24;
  localparam int ACC_W       = 39;
  localparam int G_W         = 36;
  localparam int PROD_W      = G_W + W_W;
  localparam int SUM_W       = 26;
  localparam int RND_W       = PROD_W + 1 - 32;
  localparam int SIG_ENTRIES = 512;
  localparam int SIG_IDX_W   = 9;
  localparam int SIG_STEP    = SIG_ENTRIES / 6 / 2;
  localparam int SIG_LIMIT   = 24576;

  // Unity in the Q2.14 coefficient format.
  localparam logic [15:0] COEF_ONE = 16'd16384;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TRAIN = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PAIR_POS    = 2'd0,
    PAIR_NEG    = 2'd1,
    PAIR_STRONG = 2'd2,
    PAIR_WEAK   = 2'd3
  } pair_t;

  typedef enum logic [1:0] {
    CFG_LEARN_RATE  = 2'd0,
    CFG_BETA_STRONG = 2'd1,
    CFG_BETA_WEAK   = 2'd2,
    CFG_DIM_IN_USE  = 2'd3
  } cfg_idx_t;

  typedef logic [15:0] sig_rom_t [SIG_ENTRIES];

  // Saturate a wide sum to a 16 bit weight.
  function automatic logic signed [W_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32767);
    lo = -SUM_W'(32768);
    if (v > hi) return 16'sh7fff;
    else if (v < lo) return 16'sh8000;
    else return v[W_W-1:0];
  endfunction

  // Saturate a wide sum to a 24 bit accumulator value.
  function automatic logic signed [H_W-1:0] sat_h(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(8388607);
    lo = -SUM_W'(8388608);
    if (v > hi) return 24'sh7fffff;
    else if (v < lo) return 24'sh800000;
    else return v[H_W-1:0];
  endfunction

  // Unsigned long division by shift and subtract, for non-negative operands.
  function automatic longint udiv(input longint n, input longint dv);
    longint q, r;
    int b;
    q = 0;
    r = 0;
    for (b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & longint'(1));
      if (r >= dv) begin
        r = r - dv;
        q = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // Sigmoid table, built once at elaboration from a series for exp and repeated squaring.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    longint d, a, y, p2, p3, p4, e, den, s;
    int i, k;
    for (i = 0; i < SIG_ENTRIES; i++) begin
      d = 2 * longint'(i) - longint'(SIG_ENTRIES);
      a = (d < 0) ? -d : d;
      y = (a * 3 * (longint'(1) <<< 26)) >>> SIG_IDX_W;
      p2 = (y * y) >>> 31;
      p3 = (p2 * y) >>> 31;
      p4 = (p3 * y) >>> 31;
      e = (longint'(1) <<< 31) - y + (p2 >>> 1) - udiv(p3, 6) + udiv(p4, 24);
      for (k = 0; k < 6; k++) begin
        e = (e * e) >>> 31;
      end
      den = (longint'(1) <<< 31) + e;
      if (d >= 0) s = udiv((longint'(1) <<< 47) + (den >>> 1), den);
      else s = udiv(e * 65536 + (den >>> 1), den);
      if (s > 65535) s = 65535;
      rom[i] = s[15:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ----- rtl/skipgram_pair_update_engine_core.sv -----
// Top level of the skip-gram pair update engine: weight memories, accumulator and sequencer.
//
//   channel  ports                                   timing
//   input    start, busy, in_*                       word taken when start & !busy
//   result   out_valid, out_*                        one-cycle strobe, one word per input
//   config   cfg_we, cfg_index, cfg_wdata            written on any edge with cfg_we
//
// A train item streams a row three times through one shared multiplier (dot product,
// accumulator update, output row update), each pass through a read, multiply and write-back
// pipeline; a skipped strong or weak pair leaves out the two update passes. An end-context
// item streams the row once. Reset is synchronous; it clears control state and the accumulator
// valid bits and sets the configuration registers to their defaults; the weight memories are
// not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module skipgram_pair_update_engine_core
  import sgpu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic                    in_matrix_select,
  input  logic [ROW_W-1:0]        in_context_row,
  input  logic [ROW_W-1:0]        in_target_row,
  input  logic [COL_W-1:0]        in_column,
  input  logic signed [W_W-1:0]   in_weight_value,
  input  logic [1:0]              in_pair_type,
  output logic                    out_valid,
  output logic signed [W_W-1:0]   out_read_value,
  output logic signed [DOT_W-1:0] out_dot_product,
  output logic                    out_updated,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WR, ST_RD, ST_RD_OUT, ST_DOT, ST_G1, ST_G2, ST_G3,
    ST_HID, ST_OUT, ST_ENDC
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0]      learn_rate_r, beta_strong_r, beta_weak_r;
  logic [DIM_W-1:0] dim_in_use_r;

  // Latched item fields.
  logic             msel_r;
  logic [ROW_W-1:0] crow_r, trow_r;
  logic [COL_W-1:0] col_r;
  logic signed [W_W-1:0] wval_r;
  logic [1:0]       ptype_r;
  logic [DIM_W-1:0] dim_r;

  // Stream pipeline.
  logic [DIM_W-1:0] k_r;
  logic             v1_r, v2_r;
  logic [COL_W-1:0] k1_r, k2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [H_W-1:0]    base_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Gradient path.
  logic signed [DOT_W-1:0] dot_r;
  logic                    above_r, below_r;
  logic [SIG_IDX_W-1:0]    idx_r;
  logic [31:0]             t_r;
  logic signed [G_W-1:0]   g_r;

  // Result registers.
  logic                    out_valid_r;
  logic signed [W_W-1:0]   read_value_r;
  logic signed [DOT_W-1:0] dot_product_r;
  logic                    updated_r;

  // Memories and their ports.
  logic signed [W_W-1:0] in_mem  [VOCAB_WORDS*DIM_MAX];
  logic signed [W_W-1:0] out_mem [VOCAB_WORDS*DIM_MAX];
  logic signed [H_W-1:0] hid_mem [DIM_MAX];
  logic [DIM_MAX-1:0]    hid_valid_r;
  logic signed [W_W-1:0] in_q, out_q;
  logic signed [H_W-1:0] hid_q;
  logic                  hid_vq;
  logic signed [H_W-1:0] hid_eff;

  logic                  in_we, out_we, hid_we, hid_clear;
  logic [ADDR_W-1:0]     in_ra, out_ra, in_wa, out_wa;
  logic signed [W_W-1:0] in_wd, out_wd;
  logic signed [H_W-1:0] hid_wd;

  logic issue, phase_done, streaming;
  logic signed [G_W-1:0]    mul_a;
  logic signed [W_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W:0]   rsum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  wb_sum;
  logic signed [W_W-1:0]    wb_w;
  logic signed [H_W-1:0]    wb_h;

  // Gradient helpers.
  logic signed [DOT_W:0]   dot_off;
  logic [21:0]             idx_prod;
  logic [SIG_IDX_W:0]      idx_raw;
  logic [15:0]             sig_s;
  logic signed [17:0]      x_val;
  logic [15:0]             coef;
  logic signed [50:0]      gx_prod;
  logic                    skip;
  logic signed [ACC_W-13:0] acc_sh;
  logic [DIM_W-1:0]        dim_clip;

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = read_value_r;
  assign out_dot_product = dot_product_r;
  assign out_updated     = updated_r;

  assign streaming  = (state_r == ST_DOT) || (state_r == ST_HID) ||
                      (state_r == ST_OUT) || (state_r == ST_ENDC);
  assign issue      = streaming && (k_r < dim_r);
  assign phase_done = (k_r == dim_r) && !v1_r && !v2_r;
  assign hid_eff    = hid_vq ? hid_q : '0;
  assign dim_clip   = (dim_in_use_r > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_in_use_r;

  // Shared multiplier operands: the dot pass multiplies two weights, the update passes
  // multiply the gradient by a weight.
  always_comb begin
    mul_a = (state_r == ST_DOT) ? G_W'(in_q) : g_r;
    mul_b = (state_r == ST_OUT) ? in_q : out_q;
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round half up from Q.44 to Q.12 (end-context: unrounded) and add to the stored value.
  always_comb begin
    rsum = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(64'sd2147483648);
    rnd  = rsum[PROD_W:32];
    if (state_r == ST_ENDC) wb_sum = SUM_W'(base_r) + SUM_W'(signed'(prod_r[H_W-1:0]));
    else wb_sum = SUM_W'(base_r) + SUM_W'(rnd);
    wb_w = sat_w(wb_sum);
    wb_h = sat_h(wb_sum);
  end

  // Memory port control.
  always_comb begin
    in_ra     = {crow_r, k_r[COL_W-1:0]};
    out_ra    = {trow_r, k_r[COL_W-1:0]};
    in_we     = 1'b0;
    out_we    = 1'b0;
    hid_we    = 1'b0;
    hid_clear = 1'b0;
    in_wa     = {crow_r, k2_r};
    out_wa    = {trow_r, k2_r};
    in_wd     = wb_w;
    out_wd    = wb_w;
    hid_wd    = wb_h;
    case (state_r)
      ST_WR: begin
        in_wa  = {crow_r, col_r};
        out_wa = {crow_r, col_r};
        in_wd  = wval_r;
        out_wd = wval_r;
        in_we  = !msel_r;
        out_we = msel_r;
      end
      ST_RD: begin
        in_ra  = {crow_r, col_r};
        out_ra = {crow_r, col_r};
      end
      ST_HID:  hid_we = v2_r;
      ST_OUT:  out_we = v2_r;
      ST_ENDC: begin
        in_we     = v2_r;
        hid_clear = phase_done;
      end
      default: ;
    endcase
  end

  // Weight memories with registered read.
  always_ff @(posedge clk) begin
    if (in_we) in_mem[in_wa] <= in_wd;
    in_q <= in_mem[in_ra];
  end

  always_ff @(posedge clk) begin
    if (out_we) out_mem[out_wa] <= out_wd;
    out_q <= out_mem[out_ra];
  end

  // Hidden accumulator memory; an entry not yet written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (hid_we) hid_mem[k2_r] <= hid_wd;
    hid_q <= hid_mem[k_r[COL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hid_valid_r <= '0;
      hid_vq      <= 1'b0;
    end else begin
      hid_vq <= hid_valid_r[k_r[COL_W-1:0]];
      if (hid_clear) hid_valid_r <= '0;
      else if (hid_we) hid_valid_r[k2_r] <= 1'b1;
    end
  end

  // Gradient arithmetic: table index, learning coefficient and signed sigmoid term.
  always_comb begin
    acc_sh   = acc_r[ACC_W-1:12];
    dot_off  = (DOT_W+1)'(dot_r) + (DOT_W+1)'(SIG_LIMIT);
    idx_prod = 22'(dot_off[15:0]) * 22'(SIG_STEP);
    idx_raw  = idx_prod[21:12];
    sig_s    = SIG_ROM[idx_r];
    case (ptype_r)
      PAIR_POS, PAIR_NEG: coef = COEF_ONE;
      PAIR_STRONG:        coef = beta_strong_r;
      default:            coef = beta_weak_r;
    endcase
    skip = 1'b0;
    case (ptype_r)
      PAIR_POS: begin
        if (above_r) x_val = '0;
        else if (below_r) x_val = 18'sd65536;
        else x_val = 18'sd65536 - 18'(sig_s);
      end
      PAIR_NEG: begin
        if (above_r) x_val = -18'sd65536;
        else if (below_r) x_val = '0;
        else x_val = -18'(sig_s);
      end
      default: begin
        skip = above_r;
        if (below_r) x_val = 18'sd65536;
        else x_val = 18'sd65536 - 18'(sig_s);
      end
    endcase
    gx_prod = 51'(signed'({1'b0, t_r})) * 51'(x_val);
  end

  // Sequencer, configuration registers and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      learn_rate_r  <= 16'd1638;
      beta_strong_r <= 16'd16384;
      beta_weak_r   <= 16'd4096;
      dim_in_use_r  <= 8'd100;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      k_r           <= '0;
    end else begin
      out_valid_r <= 1'b0;

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEARN_RATE:  learn_rate_r  <= cfg_wdata;
          CFG_BETA_STRONG: beta_strong_r <= cfg_wdata;
          CFG_BETA_WEAK:   beta_weak_r   <= cfg_wdata;
          default:         dim_in_use_r  <= cfg_wdata[DIM_W-1:0];
        endcase
      end

      // Stream pipeline: read, multiply, write back.
      v1_r <= issue;
      k1_r <= k_r[COL_W-1:0];
      v2_r <= v1_r;
      k2_r <= k1_r;
      if (issue) k_r <= k_r + 1'b1;
      if (v1_r) begin
        case (state_r)
          ST_HID:  base_r <= hid_eff;
          ST_OUT:  base_r <= H_W'(out_q);
          ST_ENDC: base_r <= H_W'(in_q);
          default: base_r <= '0;
        endcase
        if (state_r == ST_ENDC) prod_r <= PROD_W'(hid_eff);
        else prod_r <= mul_p;
      end
      if (v2_r && state_r == ST_DOT) acc_r <= acc_r + prod_r[ACC_W-1:0];

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            msel_r  <= in_matrix_select;
            crow_r  <= in_context_row;
            trow_r  <= in_target_row;
            col_r   <= in_column;
            wval_r  <= in_weight_value;
            ptype_r <= in_pair_type;
            dim_r   <= dim_clip;
            k_r     <= '0;
            acc_r   <= '0;
            case (kind_t'(in_kind))
              KIND_WRITE: state_r <= ST_WR;
              KIND_READ:  state_r <= ST_RD;
              KIND_TRAIN: state_r <= ST_DOT;
              default:    state_r <= ST_ENDC;
            endcase
          end
        end
        ST_WR: begin
          out_valid_r   <= 1'b1;
          read_value_r  <= '0;
          dot_product_r <= '0;
          updated_r     <= 1'b0;
          state_r       <= ST_IDLE;
        end
        ST_RD: state_r <= ST_RD_OUT;
        ST_RD_OUT: begin
          out_valid_r   <= 1'b1;
          read_value_r  <= msel_r ? out_q : in_q;
          dot_product_r <= '0;
          updated_r     <= 1'b0;
          state_r       <= ST_IDLE;
        end
        ST_DOT: if (phase_done) state_r <= ST_G1;
        ST_G1: begin
          // Floor to Q11.12 and saturate.
          if (acc_sh > (ACC_W-12)'(8388607)) dot_r <= 24'sh7fffff;
          else if (acc_sh < -(ACC_W-12)'(8388608)) dot_r <= 24'sh800000;
          else dot_r <= acc_sh[DOT_W-1:0];
          state_r <= ST_G2;
        end
        ST_G2: begin
          above_r <= dot_r > DOT_W'(SIG_LIMIT);
          below_r <= dot_r < -DOT_W'(SIG_LIMIT);
          idx_r   <= (idx_raw > (SIG_IDX_W+1)'(SIG_ENTRIES-1)) ?
                     SIG_IDX_W'(SIG_ENTRIES-1) : idx_raw[SIG_IDX_W-1:0];
          t_r     <= 32'(learn_rate_r) * 32'(coef);
          state_r <= ST_G3;
        end
        ST_G3: begin
          if (skip) begin
            out_valid_r   <= 1'b1;
            read_value_r  <= '0;
            dot_product_r <= dot_r;
            updated_r     <= 1'b0;
            state_r       <= ST_IDLE;
          end else begin
            g_r     <= gx_prod[G_W+13:14];
            k_r     <= '0;
            state_r <= ST_HID;
          end
        end
        ST_HID: begin
          if (phase_done) begin
            k_r     <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (phase_done) begin
            out_valid_r   <= 1'b1;
            read_value_r  <= '0;
            dot_product_r <= dot_r;
            updated_r     <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        ST_ENDC: begin
          if (phase_done) begin
            out_valid_r   <= 1'b1;
            read_value_r  <= '0;
            dot_product_r <= '0;
            updated_r     <= 1'b0;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/skipgram_pair_update_engine_checker.sv -----
// Checker for the skip-gram update engine: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps
module skipgram_pair_update_engine_checker
  import sgpu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic                    in_matrix_select,
  input  logic [ROW_W-1:0]        in_context_row,
  input  logic [ROW_W-1:0]        in_target_row,
  input  logic [COL_W-1:0]        in_column,
  input  logic signed [W_W-1:0]   in_weight_value,
  input  logic [1:0]              in_pair_type,
  input  logic                    out_valid,
  input  logic signed [W_W-1:0]   out_read_value,
  input  logic signed [DOT_W-1:0] out_dot_product,
  input  logic                    out_updated,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  output int                      fail_count,
  output int                      pending,
  output int                      checked,
  output int                      trained,
  output int                      skipped
);

  typedef struct packed {
    logic signed [W_W-1:0]   rd;
    logic signed [DOT_W-1:0] dot;
    logic                    upd;
  } engine_result_t;

  engine_result_t result_q[$];

  // Shadow copy of the registers and the engine state.
  logic [15:0] rate;
  logic [15:0] beta_s;
  logic [15:0] beta_w;
  logic [7:0]  dim_reg;
  logic signed [W_W-1:0] in_mem [int];
  logic signed [W_W-1:0] out_mem [int];
  longint hidden [DIM_MAX];
  longint sigmoid [SIG_ENTRIES];

  // Clamp a value to a signed range of the given width.
  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // The sigmoid table, from a truncated series for exp(-|x|/64) raised to the 64th power.
  initial begin
    longint d, a, y, p2, p3, p4, e, den, s;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      d = 2 * longint'(i) - SIG_ENTRIES;
      a = (d < 0) ? -d : d;
      y = (a * 3 * (longint'(1) <<< 26)) / SIG_ENTRIES;
      p2 = (y * y) >>> 31;
      p3 = (p2 * y) >>> 31;
      p4 = (p3 * y) >>> 31;
      e = (longint'(1) <<< 31) - y + p2 / 2 - p3 / 6 + p4 / 24;
      for (int k = 0; k < 6; k++) e = (e * e) >>> 31;
      den = (longint'(1) <<< 31) + e;
      s = (d >= 0) ? ((longint'(1) <<< 47) + den / 2) / den : (e * 65536 + den / 2) / den;
      sigmoid[i] = (s > 65535) ? 65535 : s;
    end
  end

  // Apply one word to the shadow state and return the result it should produce.
  function automatic engine_result_t apply_word();
    engine_result_t r;
    int crow, trow, a, dim;
    longint acc, dot, g, lr, beta, s, idx, p;
    bit go;
    r = '0;
    crow = int'(in_context_row) * DIM_MAX;
    trow = int'(in_target_row) * DIM_MAX;
    a = crow + int'(in_column);
    dim = (dim_reg > DIM_MAX) ? DIM_MAX : int'(dim_reg);
    case (kind_t'(in_kind))
      KIND_WRITE: begin
        if (in_matrix_select) out_mem[a] = in_weight_value;
        else in_mem[a] = in_weight_value;
      end
      KIND_READ: begin
        r.rd = in_matrix_select ? out_mem[a] : in_mem[a];
      end
      KIND_TRAIN: begin
        acc = 0;
        for (int k = 0; k < dim; k++)
          acc += longint'(in_mem[crow + k]) * longint'(out_mem[trow + k]);
        dot = clamp(acc >>> 12, DOT_W);
        r.dot = dot[DOT_W-1:0];
        lr = longint'(rate);
        beta = longint'((pair_t'(in_pair_type) == PAIR_STRONG) ? beta_s : beta_w);
        go = 1'b1;
        g = 0;
        if (dot > SIG_LIMIT) begin
          case (pair_t'(in_pair_type))
            PAIR_POS: g = 0;
            PAIR_NEG: g = -lr * 65536;
            default:  go = 1'b0;
          endcase
        end else if (dot < -SIG_LIMIT) begin
          case (pair_t'(in_pair_type))
            PAIR_POS: g = lr * 65536;
            PAIR_NEG: g = 0;
            default:  g = (lr * beta * 65536) >>> 14;
          endcase
        end else begin
          idx = ((dot + SIG_LIMIT) * SIG_STEP) >>> 12;
          if (idx > SIG_ENTRIES - 1) idx = SIG_ENTRIES - 1;
          s = sigmoid[idx];
          case (pair_t'(in_pair_type))
            PAIR_POS: g = lr * (65536 - s);
            PAIR_NEG: g = -lr * s;
            default:  g = (lr * beta * (65536 - s)) >>> 14;
          endcase
        end
        if (go) begin
          // Accumulator first from the old output row, then the output row from the input row.
          for (int k = 0; k < dim; k++) begin
            p = (g * longint'(out_mem[trow + k]) + (longint'(1) <<< 31)) >>> 32;
            hidden[k] = clamp(hidden[k] + p, H_W);
          end
          for (int k = 0; k < dim; k++) begin
            p = (g * longint'(in_mem[crow + k]) + (longint'(1) <<< 31)) >>> 32;
            out_mem[trow + k] = W_W'(clamp(longint'(out_mem[trow + k]) + p, W_W));
          end
          r.upd = 1'b1;
          trained++;
        end else begin
          skipped++;
        end
      end
      default: begin
        for (int k = 0; k < dim; k++)
          in_mem[crow + k] = W_W'(clamp(longint'(in_mem[crow + k]) + hidden[k], W_W));
        for (int k = 0; k < DIM_MAX; k++) hidden[k] = 0;
      end
    endcase
    return r;
  endfunction

  // Register writes, result comparison and prediction of accepted words.
  always @(posedge clk) begin
    engine_result_t want;
    if (!rst_n) begin
      rate <= 16'd1638;
      beta_s <= 16'd16384;
      beta_w <= 16'd4096;
      dim_reg <= 8'd100;
      for (int k = 0; k < DIM_MAX; k++) hidden[k] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEARN_RATE:  rate <= cfg_wdata;
          CFG_BETA_STRONG: beta_s <= cfg_wdata;
          CFG_BETA_WEAK:   beta_w <= cfg_wdata;
          default:         dim_reg <= cfg_wdata[7:0];
        endcase
      end
      if (out_valid) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: read %0d dot %0d updated %0b",
                   $time, out_read_value, out_dot_product, out_updated);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (out_read_value !== want.rd) begin
            fail_count++;
            $display("%0t: read_value expected %0d actual %0d", $time, want.rd,
                     out_read_value);
          end
          if (out_dot_product !== want.dot) begin
            fail_count++;
            $display("%0t: dot_product expected %0d actual %0d", $time, want.dot,
                     out_dot_product);
          end
          if (out_updated !== want.upd) begin
            fail_count++;
            $display("%0t: updated expected %0b actual %0b", $time, want.upd, out_updated);
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_word());
    end
    pending = result_q.size();
  end

endmodule

// ----- sim/skipgram_pair_update_engine_core_tb.sv -----
// Testbench top for the skip-gram update engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module skipgram_pair_update_engine_core_tb;
  import sgpu_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_kind;
  logic in_matrix_select;
  logic [ROW_W-1:0] in_context_row;
  logic [ROW_W-1:0] in_target_row;
  logic [COL_W-1:0] in_column;
  logic signed [W_W-1:0] in_weight_value;
  logic [1:0] in_pair_type;
  logic out_valid;
  logic signed [W_W-1:0] out_read_value;
  logic signed [DOT_W-1:0] out_dot_product;
  logic out_updated;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  int fail_count, pending, checked, trained, skipped;
  int words_sent;
  int idle_pct;
  int quiet_cycles;
  bit start_hi;

  // Rows that are fully written before use; only these are ever read.
  localparam int NROWS = 2;
  localparam logic [ROW_W-1:0] ROW_POOL [NROWS] = '{12'd0, 12'hfff};
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 12;

  skipgram_pair_update_engine_core DUT (.*);

  skipgram_pair_update_engine_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until the engine takes it.
  task automatic send_word(input kind_t k, input logic sel, input logic [ROW_W-1:0] crow,
                           input logic [ROW_W-1:0] trow, input logic [COL_W-1:0] col,
                           input logic signed [W_W-1:0] wval, input pair_t pt);
    start <= 1'b1;
    start_hi = 1'b1;
    in_kind <= k;
    in_matrix_select <= sel;
    in_context_row <= crow;
    in_target_row <= trow;
    in_column <= col;
    in_weight_value <= wval;
    in_pair_type <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      start_hi = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every expected word and for the engine to go idle.
  task automatic drain();
    if (start_hi) start <= 1'b0;
    start_hi = 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] lr, input logic [15:0] bs,
                            input logic [15:0] bw, input logic [7:0] dim);
    logic [15:0] vals [4];
    vals = '{lr, bs, bw, {8'd0, dim}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] pool_row();
    return ROW_POOL[$urandom_range(NROWS - 1)];
  endfunction

  function automatic logic signed [W_W-1:0] rand_weight();
    if ($urandom_range(1)) return W_W'($urandom);
    return W_W'($signed($urandom_range(4095)) - 2048);
  endfunction

  // One random word: mostly training within the written rows, the rest accesses and ends.
  task automatic random_word();
    int pick;
    logic [ROW_W-1:0] wrow;
    pick = $urandom_range(99);
    wrow = ($urandom_range(4) == 0) ? ROW_W'($urandom) : pool_row();
    if (pick < 55)
      send_word(KIND_TRAIN, 1'($urandom), pool_row(), pool_row(), 7'($urandom), 16'($urandom),
                pair_t'($urandom_range(3)));
    else if (pick < 65)
      send_word(KIND_END, 1'($urandom), pool_row(), ROW_W'($urandom), 7'($urandom),
                16'($urandom), pair_t'($urandom_range(3)));
    else if (pick < 85)
      send_word(KIND_READ, 1'($urandom), pool_row(), ROW_W'($urandom), 7'($urandom),
                16'($urandom), pair_t'($urandom_range(3)));
    else
      send_word(KIND_WRITE, 1'($urandom), wrow, ROW_W'($urandom), 7'($urandom),
                rand_weight(), pair_t'($urandom_range(3)));
  endtask

  initial begin
    logic signed [W_W-1:0] w;
    int pcts [6];
    pcts = '{0, 61, 33, 0, 61, 33};
    words_sent = 0;
    idle_pct = 0;
    start_hi = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_WRITE;
    in_matrix_select = 1'b0;
    in_context_row = '0;
    in_target_row = '0;
    in_column = '0;
    in_weight_value = '0;
    in_pair_type = PAIR_POS;
    cfg_we = 1'b0;
    cfg_index = CFG_LEARN_RATE;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the row pool: small and large magnitudes of both signs so all sigmoid regions appear.
    for (int r = 0; r < NROWS; r++) begin
      for (int m = 0; m < 2; m++) begin
        for (int c = 0; c < DIM_MAX; c++) begin
          case (r)
            0: w = m ? -16'sd16384 : W_W'($signed($urandom_range(1023)) - 512);
            default: w = 16'sd16384;
          endcase
          send_word(KIND_WRITE, 1'(m), ROW_POOL[r], '0, 7'(c), w, PAIR_POS);
        end
      end
    end

    // Directed words: field extremes, every kind and pair type, both clamp regions.
    send_word(KIND_READ, 1'b0, 12'd0, 12'hfff, 7'd0, 16'sh7fff, PAIR_WEAK);
    send_word(KIND_READ, 1'b1, 12'hfff, 12'd0, 7'd127, 16'sh8000, PAIR_POS);
    send_word(KIND_WRITE, 1'b0, 12'hfff, 12'hfff, 7'd127, 16'sh7fff, PAIR_WEAK);
    send_word(KIND_WRITE, 1'b1, 12'd0, 12'd0, 7'd0, 16'sh8000, PAIR_POS);
    send_word(KIND_READ, 1'b0, 12'hfff, 12'd0, 7'd127, 16'sh0, PAIR_POS);
    send_word(KIND_READ, 1'b1, 12'd0, 12'hfff, 7'd0, 16'shffff, PAIR_WEAK);
    send_word(KIND_TRAIN, 1'b0, 12'd0, 12'd0, 7'd0, 16'sh0, PAIR_POS);
    send_word(KIND_TRAIN, 1'b1, 12'hfff, 12'd0, 7'd127, 16'shffff, PAIR_NEG);
    send_word(KIND_TRAIN, 1'b0, 12'd0, 12'hfff, 7'd0, 16'sh0, PAIR_STRONG);
    send_word(KIND_TRAIN, 1'b0, 12'd0, 12'hfff, 7'd0, 16'sh0, PAIR_WEAK);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'hfff, 7'd0, 16'sh0, PAIR_STRONG);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'hfff, 7'd0, 16'sh0, PAIR_WEAK);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'hfff, 7'd0, 16'sh0, PAIR_POS);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'hfff, 7'd0, 16'sh0, PAIR_NEG);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'd0, 7'd0, 16'sh0, PAIR_POS);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'd0, 7'd0, 16'sh0, PAIR_NEG);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'd0, 7'd0, 16'sh0, PAIR_STRONG);
    send_word(KIND_TRAIN, 1'b0, 12'hfff, 12'd0, 7'd0, 16'sh0, PAIR_WEAK);
    send_word(KIND_END, 1'b1, 12'd0, 12'hfff, 7'd127, 16'shffff, PAIR_WEAK);
    send_word(KIND_READ, 1'b0, 12'd0, 12'd0, 7'd64, 16'sh0, PAIR_POS);
    send_word(KIND_END, 1'b0, 12'hfff, 12'd0, 7'd0, 16'sh0, PAIR_POS);

    // Random phases, each under its own register setting and idling rate.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_regs(16'hffff, 16'hffff, 16'hffff, 8'd128);
        1: write_regs(16'h0, 16'h0, 16'h0, 8'd0);
        2: write_regs(16'($urandom), 16'($urandom), 16'($urandom), 8'd255);
        3: write_regs(16'd1638, 16'd16384, 16'd4096, 8'd1);
        4: write_regs(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 128)));
        default: write_regs(16'($urandom_range(8000)), 16'($urandom), 16'($urandom), 8'd64);
      endcase
      idle_pct = pcts[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Hold off once until the engine has caught up completely.
        if (ph == 2 && n == PHASE_WORDS / 2) drain();
        random_word();
      end
    end

    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d words and checked %0d results: %0d trainings applied, %0d skipped,",
             words_sent, checked, trained, skipped);
    $display("across six register settings including zero and oversized dimensions.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
